[hdl/wtc_pkg.sv]
// shared constants and types of the word tokenize and count unit
package wtc_pkg;
    localparam int MAX_WORD_LEN = 16;
    localparam int TABLE_SLOTS  = 4096;
    localparam int WORD_W  = MAX_WORD_LEN * 8;
    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int POS_W   = $clog2(MAX_WORD_LEN);
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PROBE_W = SLOT_W + 1;
    localparam int LIMIT_W = 13;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam int LIMIT_RAW = (TABLE_SLOTS * 7) / 10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET =
        (LIMIT_RAW > 8191) ? {LIMIT_W{1'b1}} : LIMIT_W'(LIMIT_RAW);

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_INSERT  = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] chars;
        logic [31:0]       hash;
        logic [LEN_W-1:0]  len;
    } t_word;
endpackage

[hdl/word_tokenize_and_count_unit.sv]
// top level of the word tokenize and count unit
// Usage:
// - input channel: i_in_valid with i_text_byte and i_flush, o_in_stall back.
//   a transfer happens on a clock edge with valid high and stall low.
// - bytes are taken one per cycle while the two-entry word queue has room.
// - each finished word gives one result on the output channel o_out_valid,
//   held with its fields until a cycle with i_out_stall low.
// - a word is taken from the queue, then each probed slot is read in the wait
//   state and compared in the check state, as set by the registered read of
//   the slot memories; the check state holds while the result register is stalled.
// - a byte that ends no word pushes nothing into the queue.
// - reset clears the tokenizer and then sweeps the used marks of all 4096 slots,
//   one slot a cycle; bytes are still taken into the queue meanwhile.
// - entry_limit is written by i_cfg_we and i_cfg_data; write it only while idle, the block does not enforce this.
// - a stalled receiver holds the result register; the engine waits, the
//   queue fills and then o_in_stall rises.
module word_tokenize_and_count_unit import wtc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_flush,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [31:0]        o_word_count,
    output logic [11:0]        o_slot_index,
    output logic [31:0]        o_word_hash,
    output logic [4:0]         o_word_length
);
    logic [LIMIT_W-1:0] r_limit;
    logic  push, pop, full, empty;
    t_word push_word, pop_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_in_stall = full;

    wtc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(i_in_valid && !full),
        .i_text_byte(i_text_byte), .i_flush(i_flush),
        .o_push(push), .o_word(push_word));

    wtc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(push_word),
        .i_pop(pop), .o_word(pop_word), .o_full(full), .o_empty(empty));

    wtc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_limit(r_limit),
        .i_word(pop_word), .i_empty(empty), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_word_count(o_word_count),
        .o_slot_index(o_slot_index), .o_word_hash(o_word_hash),
        .o_word_length(o_word_length));
endmodule

[hdl/wtc_ram.sv]
// generic single-write, single-read ram with registered read
module wtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/wtc_front.sv]
// tokenizer: lowercases bytes, builds the pending word and its fnv-1a hash
module wtc_front import wtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_flush,
    output logic       o_push,
    output t_word      o_word
);
    logic [WORD_W-1:0] r_chars, n_chars;
    logic [31:0]       r_hash, n_hash;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_discard, n_discard;

    logic              upper, letter;
    logic [7:0]        c;
    logic [WORD_W-1:0] app_chars;
    logic [31:0]       app_hash;
    logic [LEN_W-1:0]  app_len;

    assign upper  = (i_text_byte >= 8'h41) && (i_text_byte <= 8'h5a);
    assign letter = upper || ((i_text_byte >= 8'h61) && (i_text_byte <= 8'h7a));
    assign c      = upper ? i_text_byte + 8'd32 : i_text_byte;
    assign app_hash = (r_hash ^ {24'd0, c}) * FNV_PRIME;
    assign app_len  = r_len + LEN_W'(1);

    always_comb begin
        app_chars = r_chars;
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            if (r_len[POS_W-1:0] == POS_W'(k)) begin
                app_chars[k*8 +: 8] = c;
            end
        end
    end

    always_comb begin
        n_chars   = r_chars;
        n_hash    = r_hash;
        n_len     = r_len;
        n_discard = r_discard;
        o_push    = 1'b0;
        o_word    = '{chars: r_chars, hash: r_hash, len: r_len};
        if (i_accept) begin
            if (i_flush) begin
                n_discard = 1'b0;
                if (r_len != '0) begin
                    o_push = 1'b1;
                    n_chars = '0;
                    n_hash  = FNV_BASIS;
                    n_len   = '0;
                end
            end else if (r_discard) begin
                n_discard = 1'b0;
            end else if (r_len == '0 && !letter) begin
                n_len = r_len;
            end else if (r_len != '0 && !letter && i_text_byte != 8'h27) begin
                o_push  = 1'b1;
                n_chars = '0;
                n_hash  = FNV_BASIS;
                n_len   = '0;
            end else if (app_len == LEN_W'(MAX_WORD_LEN)) begin
                // full-length word ends here, the next byte is dropped
                o_push    = 1'b1;
                o_word    = '{chars: app_chars, hash: app_hash, len: app_len};
                n_discard = 1'b1;
                n_chars   = '0;
                n_hash    = FNV_BASIS;
                n_len     = '0;
            end else begin
                n_chars = app_chars;
                n_hash  = app_hash;
                n_len   = app_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars   <= '0;
            r_hash    <= FNV_BASIS;
            r_len     <= '0;
            r_discard <= 1'b0;
        end else begin
            r_chars   <= n_chars;
            r_hash    <= n_hash;
            r_len     <= n_len;
            r_discard <= n_discard;
        end
    end
endmodule

[hdl/wtc_fifo.sv]
// two-entry queue of finished words between tokenizer and table engine
module wtc_fifo import wtc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    input  logic  i_pop,
    output t_word o_word,
    output logic  o_full,
    output logic  o_empty
);
    t_word      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_word  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

[hdl/wtc_back.sv]
// table engine: linear probing over the slot memories and result register
module wtc_back import wtc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_limit,
    input  t_word              i_word,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [31:0]        o_word_count,
    output logic [11:0]        o_slot_index,
    output logic [31:0]        o_word_hash,
    output logic [4:0]         o_word_length
);
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [PROBE_W-1:0] r_probe, n_probe;
    logic [LIMIT_W-1:0] r_entries, n_entries;
    t_word              r_cur, n_cur;
    logic               r_ov, n_ov;
    logic [1:0]         r_st, n_st;
    logic [31:0]        r_cnt, n_cnt;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [31:0]        r_hash;
    logic [LEN_W-1:0]   r_len;

    logic              used_we, used_wd, used_rd;
    logic [SLOT_W-1:0] used_wa;
    logic              data_we;
    logic [31:0]       cnt_wd, cnt_rd;
    logic [WORD_W-1:0] chr_rd;
    logic              emit_ok;
    logic [31:0]       cnt_inc;
    logic              res_load;

    wtc_ram #(.WIDTH(1), .DEPTH(TABLE_SLOTS)) u_used (
        .i_clk(i_clk), .i_we(used_we), .i_waddr(used_wa), .i_wdata(used_wd),
        .i_raddr(r_idx), .o_rdata(used_rd));
    wtc_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_count (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(r_idx), .i_wdata(cnt_wd),
        .i_raddr(r_idx), .o_rdata(cnt_rd));
    wtc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SLOTS)) u_chars (
        .i_clk(i_clk), .i_we(data_we && !used_rd), .i_waddr(r_idx),
        .i_wdata(r_cur.chars), .i_raddr(r_idx), .o_rdata(chr_rd));

    assign emit_ok = !r_ov || !i_out_stall;
    assign cnt_inc = (cnt_rd == 32'hffff_ffff) ? cnt_rd : cnt_rd + 32'd1;
    // a new result enters the output register
    assign res_load = n_ov && !(r_ov && i_out_stall);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_probe   = r_probe;
        n_entries = r_entries;
        n_cur     = r_cur;
        n_ov      = r_ov && i_out_stall;
        n_st      = r_st;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        o_pop     = 1'b0;
        used_we   = 1'b0;
        used_wa   = r_idx;
        used_wd   = 1'b1;
        data_we   = 1'b0;
        cnt_wd    = 32'd1;
        case (r_state)
            S_CLEAR: begin
                used_we = 1'b1;
                used_wd = 1'b0;
                n_idx   = r_idx + SLOT_W'(1);
                if (r_idx == {SLOT_W{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cur   = i_word;
                    n_idx   = i_word.hash[SLOT_W-1:0];
                    n_probe = '0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_CHECK;
            S_CHECK: begin
                if (emit_ok) begin
                    if (!used_rd) begin
                        n_ov = 1'b1; n_slot = r_idx; n_state = S_IDLE;
                        if (r_entries >= i_limit) begin
                            n_st = ST_DROPPED; n_cnt = 32'd0;
                        end else begin
                            used_we = 1'b1; data_we = 1'b1;
                            n_entries = r_entries + LIMIT_W'(1);
                            n_st = ST_INSERT; n_cnt = 32'd1;
                        end
                    end else if (chr_rd == r_cur.chars) begin
                        data_we = 1'b1; cnt_wd = cnt_inc;
                        n_ov = 1'b1; n_slot = r_idx; n_state = S_IDLE;
                        n_st = ST_FOUND; n_cnt = cnt_inc;
                    end else if (r_probe == PROBE_W'(TABLE_SLOTS - 1)) begin
                        n_ov = 1'b1; n_slot = '0; n_state = S_IDLE;
                        n_st = ST_FULL; n_cnt = 32'd0;
                    end else begin
                        // slot taken by another word, step to the next one
                        n_idx   = r_idx + SLOT_W'(1);
                        n_probe = r_probe + PROBE_W'(1);
                        n_state = S_WAIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_entries <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_entries <= n_entries;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_cur   <= n_cur;
        r_st    <= n_st;
        r_cnt   <= n_cnt;
        r_slot  <= n_slot;
        if (res_load) begin
            r_hash <= r_cur.hash;
            r_len  <= r_cur.len;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_st;
    assign o_word_count  = r_cnt;
    assign o_slot_index  = 12'(r_slot);
    assign o_word_hash   = r_hash;
    assign o_word_length = 5'(r_len);
endmodule

[hdl/wtc_checker.sv]
// port-level checks of the word tokenize and count unit, bound to the top
module wtc_checker import wtc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_word_count,
    input logic [11:0] o_slot_index,
    input logic [4:0]  o_word_length
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_count)
            && $stable(o_status) && $stable(o_slot_index))
        else $error("stalled result changed");
    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_INSERT |-> o_word_count == 32'd1)
        else $error("new word count not one");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_slot_index == 12'd0
            && o_word_count == 32'd0)
        else $error("exhausted probe fields wrong");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_DROPPED |-> o_word_count == 32'd0)
        else $error("dropped word has a count");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_word_length != 5'd0
            && o_word_length <= 5'(MAX_WORD_LEN))
        else $error("word length out of range");
endmodule

bind word_tokenize_and_count_unit wtc_checker u_wtc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_status(o_status),
    .o_word_count(o_word_count), .o_slot_index(o_slot_index),
    .o_word_length(o_word_length));

[dv/word_tokenize_and_count_unit_tb.sv]
// testbench for the word tokenize and count unit: byte stream in, word counts checked
module word_tokenize_and_count_unit_tb;
    import wtc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] count;
        logic [11:0] slot;
        logic [31:0] hash;
        logic [4:0]  len;
    } t_tally;

    // behavioral copy of the tokenizer and table, plus the queue of expected tallies
    class word_tally_board;
        logic [LIMIT_W-1:0] limit;
        bit                 used[TABLE_SLOTS];
        logic [31:0]        cnt[TABLE_SLOTS];
        logic [WORD_W-1:0]  chars[TABLE_SLOTS];
        int unsigned        in_use;
        logic [WORD_W-1:0]  pend;
        int unsigned        plen;
        logic [31:0]        h;
        bit                 skip;
        t_tally             pending_q[$];
        int                 errors;

        function void clear();
            limit = LIMIT_RESET;
            foreach (used[i]) used[i] = 0;
            in_use = 0;
            pend = '0;
            plen = 0;
            h = FNV_BASIS;
            skip = 0;
            pending_q.delete();
            errors = 0;
        endfunction

        function void close_word();
            t_tally t;
            int unsigned base;
            int unsigned idx;
            t.status = ST_FULL;
            t.count = 0;
            t.slot = 0;
            t.hash = h;
            t.len = plen[4:0];
            base = h % TABLE_SLOTS;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                idx = (base + i) % TABLE_SLOTS;
                if (!used[idx]) begin
                    t.slot = idx[11:0];
                    if (in_use >= limit) begin
                        t.status = ST_DROPPED;
                    end else begin
                        chars[idx] = pend;
                        cnt[idx] = 1;
                        used[idx] = 1;
                        in_use++;
                        t.status = ST_INSERT;
                        t.count = 1;
                    end
                    break;
                end
                if (chars[idx] == pend) begin
                    if (cnt[idx] != 32'hFFFF_FFFF) cnt[idx]++;
                    t.slot = idx[11:0];
                    t.count = cnt[idx];
                    t.status = ST_FOUND;
                    break;
                end
            end
            pending_q.push_back(t);
            pend = '0;
            plen = 0;
            h = FNV_BASIS;
        endfunction

        function void note_byte(logic [7:0] b, logic fl);
            bit up;
            bit let_ok;
            logic [7:0] c;
            up = (b >= "A" && b <= "Z");
            let_ok = up || (b >= "a" && b <= "z");
            if (fl) begin
                skip = 0;
                if (plen > 0) close_word();
                return;
            end
            if (skip) begin
                skip = 0;
                return;
            end
            if (plen == 0) begin
                if (!let_ok) return;
            end else if (!let_ok && b != "'") begin
                close_word();
                return;
            end
            c = up ? b + 8'd32 : b;
            pend[plen*8 +: 8] = c;
            plen++;
            h = (h ^ {24'd0, c}) * FNV_PRIME;
            if (plen >= MAX_WORD_LEN) begin
                skip = 1;
                close_word();
            end
        endfunction

        function void check(t_tally a);
            t_tally e;
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer, hash %h", a.hash);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.count !== e.count) begin
                $error("word_count exp %0d got %0d", e.count, a.count); errors++;
            end
            if (a.slot !== e.slot) begin
                $error("slot_index exp %0d got %0d", e.slot, a.slot); errors++;
            end
            if (a.hash !== e.hash) begin
                $error("word_hash exp %h got %h", e.hash, a.hash); errors++;
            end
            if (a.len !== e.len) begin
                $error("word_length exp %0d got %0d", e.len, a.len); errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [LIMIT_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [7:0]         i_text_byte = '0;
    logic               i_flush = 0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic [1:0]         o_status;
    logic [31:0]        o_word_count;
    logic [11:0]        o_slot_index;
    logic [31:0]        o_word_hash;
    logic [4:0]         o_word_length;

    word_tokenize_and_count_unit u_dut (.*);

    always #6 i_clk = ~i_clk;

    word_tally_board board = new();
    longint cycles = 0;
    int stall_mode = 0;

    always @(posedge i_clk) begin
        t_tally got;
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = o_status;
            got.count = o_word_count;
            got.slot = o_slot_index;
            got.hash = o_word_hash;
            got.len = o_word_length;
            board.check(got);
        end
    end

    // receiver stall pattern: off, light random, heavy random
    always @(negedge i_clk) begin
        case (stall_mode)
            0: begin
                i_out_stall <= 0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_out_stall <= (($urandom_range(0, 15) < 10));
            end
        endcase
    end

    int gap_left = 0;
    int burst_left = 0;

    // one byte transfer; bursts and gaps between them
    task automatic send_byte(logic [7:0] b, logic fl);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left != 0) begin
                i_in_valid <= 0;
                repeat (gap_left) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1;
        i_text_byte <= b;
        i_flush <= fl;
        do @(posedge i_clk); while (o_in_stall);
        board.note_byte(b, fl);
        @(negedge i_clk);
    endtask

    task automatic send_word(string s);
        foreach (s[i]) send_byte(s[i], 0);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.limit = v;
    endtask

    function automatic logic [7:0] pick_char(int wide);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'(8'("a") + $urandom_range(0, wide));
        if (r < 6) return 8'(8'("A") + $urandom_range(0, wide));
        if (r == 6) return "'";
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(int n, int wide);
        int k;
        int wl;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 9) < 8) begin
                wl = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
                send_byte(8'(8'("a") + $urandom_range(0, wide)), 0);
                for (int j = 1; j < wl; j++) send_byte(pick_char(wide), 0);
                k += wl;
                case ($urandom_range(0, 5))
                    0: send_byte(8'd0, 1);
                    1: send_byte(8'($urandom_range(128, 255)), 0);
                    default: send_byte(" ", 0);
                endcase
            end else begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            k++;
        end
        send_byte(8'($urandom_range(0, 255)), 1);
    endtask

    initial begin
        board.clear();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        // directed: case folding, apostrophes, ends, flushes, long words, limit
        send_word("Hello hello HELLO ");
        send_word("don't'Z");
        send_byte(8'hFF, 0);
        send_byte(8'h80, 1);
        send_byte(8'h00, 1);
        send_word("abcdefghijklmnopQrst");
        send_byte(8'd0, 1);
        send_word("ABCDEFGHIJKLMNOP'xy ");
        send_word("z{@`[");
        send_byte(8'h7F, 0);
        send_byte(8'h41, 1);
        write_limit(0);
        send_word("fresh hello ");
        write_limit(13'h1FFF);
        stall_mode = 1;
        random_phase(250, 25);
        drain();
        write_limit(5);
        stall_mode = 2;
        random_phase(150, 3);
        write_limit(4096);
        stall_mode = 1;
        random_phase(300, 25);
        write_limit(LIMIT_RESET);
        stall_mode = 0;
        random_phase(150, 25);
        drain();
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
